// File: rtl/core/phbog_pkg.sv
`default_nettype none

package phbog_pkg;

    // Field widths fixed by the interface.
    localparam int COORD_W = 21;
    localparam int RES_W   = 16;
    localparam int COST_W  = 16;
    localparam int CLS_W   = 2;
    localparam int CELL_W  = 8;
    localparam int APB_AW  = 5;
    localparam int APB_DW  = 32;

    // Default grid size.
    localparam int GRID_X_DEF = 256;
    localparam int GRID_Y_DEF = 256;

    // Divider: magnitude of (origin - coordinate) always fits in 21 bits.
    localparam int DIV_W     = COORD_W;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int DIFF_W    = COORD_W + 1;

    // Cell classes.
    localparam logic [CLS_W-1:0] CLS_EMPTY = 2'd0;
    localparam logic [CLS_W-1:0] CLS_SEEN  = 2'd1;
    localparam logic [CLS_W-1:0] CLS_OCC   = 2'd2;
    localparam logic [CLS_W-1:0] CLS_BAD   = 2'd3;

    // Register indexes.
    localparam logic [2:0] REG_ORIGIN_X   = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y   = 3'd1;
    localparam logic [2:0] REG_RESOLUTION = 3'd2;
    localparam logic [2:0] REG_MAX_HEIGHT = 3'd3;
    localparam logic [2:0] REG_MIN_HEIGHT = 3'd4;
    localparam logic [2:0] REG_FREE_VAL   = 3'd5;
    localparam logic [2:0] REG_OCC_VAL    = 3'd6;
    localparam logic [2:0] REG_BG_VAL     = 3'd7;

    // Reset values of the registers.
    localparam logic [COORD_W-1:0] RST_ORIGIN_X   = 21'd0;
    localparam logic [COORD_W-1:0] RST_ORIGIN_Y   = 21'd0;
    localparam logic [RES_W-1:0]   RST_RESOLUTION = 16'd100;
    localparam logic [COORD_W-1:0] RST_MAX_HEIGHT = 21'd2000;
    localparam logic [COORD_W-1:0] RST_MIN_HEIGHT = 21'h1FFC18;
    localparam logic [COST_W-1:0]  RST_FREE_VAL   = 16'd0;
    localparam logic [COST_W-1:0]  RST_OCC_VAL    = 16'd100;
    localparam logic [COST_W-1:0]  RST_BG_VAL     = 16'd0;

    typedef struct packed {
        logic [COORD_W-1:0] origin_x;
        logic [COORD_W-1:0] origin_y;
        logic [RES_W-1:0]   resolution;
        logic [COORD_W-1:0] max_height;
        logic [COORD_W-1:0] min_height;
        logic [COST_W-1:0]  free_value;
        logic [COST_W-1:0]  occupied_value;
        logic [COST_W-1:0]  background_value;
    } t_cfg;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic             rem_nz;
    } t_div_res;

endpackage

`default_nettype wire

// File: rtl/core/phbog_ram.sv
`default_nettype none

module phbog_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/core/phbog_div.sv
`default_nettype none

module phbog_div
    import phbog_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DIV_W-1:0] i_dividend,
    input  wire logic [RES_W-1:0] i_divisor,
    output t_div_res              o_res
);

    // Restoring radix-2 divider, one quotient bit per cycle, MSB first.
    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_quo;
    logic [RES_W-1:0]     r_rem;
    logic [RES_W-1:0]     r_div;

    logic [RES_W:0]       w_sh;
    logic [RES_W+1:0]     w_diff;
    logic                 w_ge;

    always_comb begin
        w_sh   = {r_rem, r_quo[DIV_W-1]};
        w_diff = {1'b0, w_sh} - {2'b00, r_div};
        w_ge   = ~w_diff[RES_W+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_W - 1);
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[RES_W-1:0] : w_sh[RES_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_res.done     = r_done;
    assign o_res.quotient = r_quo;
    assign o_res.rem_nz   = |r_rem;

endmodule

`default_nettype wire

// File: rtl/core/phbog_regs.sv
`default_nettype none

module phbog_regs
    import phbog_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg       r_cfg;
    logic       w_wr;
    logic [2:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[APB_AW-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x         <= RST_ORIGIN_X;
            r_cfg.origin_y         <= RST_ORIGIN_Y;
            r_cfg.resolution       <= RST_RESOLUTION;
            r_cfg.max_height       <= RST_MAX_HEIGHT;
            r_cfg.min_height       <= RST_MIN_HEIGHT;
            r_cfg.free_value       <= RST_FREE_VAL;
            r_cfg.occupied_value   <= RST_OCC_VAL;
            r_cfg.background_value <= RST_BG_VAL;
        end else if (w_wr) begin
            case (w_idx)
                REG_ORIGIN_X:   r_cfg.origin_x         <= pwdata[COORD_W-1:0];
                REG_ORIGIN_Y:   r_cfg.origin_y         <= pwdata[COORD_W-1:0];
                REG_RESOLUTION: r_cfg.resolution       <= pwdata[RES_W-1:0];
                REG_MAX_HEIGHT: r_cfg.max_height       <= pwdata[COORD_W-1:0];
                REG_MIN_HEIGHT: r_cfg.min_height       <= pwdata[COORD_W-1:0];
                REG_FREE_VAL:   r_cfg.free_value       <= pwdata[COST_W-1:0];
                REG_OCC_VAL:    r_cfg.occupied_value   <= pwdata[COST_W-1:0];
                REG_BG_VAL:     r_cfg.background_value <= pwdata[COST_W-1:0];
                default: ;
            endcase
        end
    end

    // Signed registers read back sign-extended.
    always_comb begin
        case (w_idx)
            REG_ORIGIN_X:   prdata = APB_DW'($signed(r_cfg.origin_x));
            REG_ORIGIN_Y:   prdata = APB_DW'($signed(r_cfg.origin_y));
            REG_RESOLUTION: prdata = APB_DW'(r_cfg.resolution);
            REG_MAX_HEIGHT: prdata = APB_DW'($signed(r_cfg.max_height));
            REG_MIN_HEIGHT: prdata = APB_DW'($signed(r_cfg.min_height));
            REG_FREE_VAL:   prdata = APB_DW'(r_cfg.free_value);
            REG_OCC_VAL:    prdata = APB_DW'(r_cfg.occupied_value);
            REG_BG_VAL:     prdata = APB_DW'(r_cfg.background_value);
            default:        prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: rtl/core/point_height_band_occupancy_grid.sv
// Channel    Direction  Handshake                    Payload
// request    in         start high while busy low    i_command, i_point_x/y/z, i_cell_x/y
// result     out        o_result_valid, one cycle    o_cell_class, o_cost
// config     in/out     APB write, pready tied high  paddr, pwdata, prdata
//
// After reset the block sweeps the whole cell memory to empty, one cell per cycle,
// with busy held high. An insert keeps busy high through two passes through the
// shared 21-step divider, then a fetch state reads the cell and a modify state
// writes it; a zero cell size drops the point with no busy. A point outside the
// grid on x finishes after the first pass, on y after the second. A read inside
// the grid is busy in the fetch and modify states and strobes its result on the
// cycle after; a read outside the grid strobes on the next cycle with no busy.
// The receiver cannot stall, so results are never held back.

`default_nettype none

module point_height_band_occupancy_grid
    import phbog_pkg::*;
#(
    parameter int GRID_X = GRID_X_DEF,
    parameter int GRID_Y = GRID_Y_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic                      i_command,
    input  wire logic signed [COORD_W-1:0] i_point_x,
    input  wire logic signed [COORD_W-1:0] i_point_y,
    input  wire logic signed [COORD_W-1:0] i_point_z,
    input  wire logic [CELL_W-1:0]         i_cell_x,
    input  wire logic [CELL_W-1:0]         i_cell_y,
    output logic                           o_result_valid,
    output logic [CLS_W-1:0]               o_cell_class,
    output logic [COST_W-1:0]              o_cost,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [APB_AW-1:0]         paddr,
    input  wire logic [APB_DW-1:0]         pwdata,
    output logic [APB_DW-1:0]              prdata,
    output logic                           pready
);

    // The cell address is {x index, y index}; each part is as wide as its
    // grid dimension needs, so the memory covers the grid rounded up to
    // powers of two.
    localparam int XW    = (GRID_X > 1) ? $clog2(GRID_X) : 1;
    localparam int YW    = (GRID_Y > 1) ? $clog2(GRID_Y) : 1;
    localparam int AW    = XW + YW;
    localparam int DEPTH = 1 << AW;

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_XSTART = 8'b0000_0100,
        S_XWAIT  = 8'b0000_1000,
        S_YSTART = 8'b0001_0000,
        S_YWAIT  = 8'b0010_0000,
        S_FETCH  = 8'b0100_0000,
        S_MODIFY = 8'b1000_0000
    } t_state;

    t_cfg     w_cfg;
    t_div_res w_div;

    t_state              r_state, n_state;
    logic [AW-1:0]       r_clr, n_clr;
    logic [DIFF_W-1:0]   r_nx, n_nx;
    logic [DIFF_W-1:0]   r_ny, n_ny;
    logic                r_inband, n_inband;
    logic                r_is_read, n_is_read;
    logic [XW-1:0]       r_ix, n_ix;
    logic [AW-1:0]       r_addr, n_addr;
    logic                r_out_valid, n_out_valid;
    logic [CLS_W-1:0]    r_out_class, n_out_class;
    logic [COST_W-1:0]   r_out_cost, n_out_cost;

    logic                w_accept;
    logic                w_on_y;
    logic [DIFF_W-1:0]   w_cur_n;
    logic [DIFF_W-1:0]   w_abs_n;
    logic                w_pos;
    logic [DIFF_W-1:0]   w_q_ceil;
    logic [DIFF_W-1:0]   w_idx;
    logic                w_idx_base_ok;
    logic                w_x_ok;
    logic                w_y_ok;
    logic [31:0]         w_cx_ext;
    logic [31:0]         w_cy_ext;
    logic                w_cell_in_grid;
    logic                w_div_start;
    logic                w_ram_we;
    logic [AW-1:0]       w_ram_addr;
    logic [CLS_W-1:0]    w_ram_wdata;
    logic [CLS_W-1:0]    w_ram_rdata;
    logic [CLS_W-1:0]    w_new_cls;

    function automatic logic [COST_W-1:0] f_cost(input logic [CLS_W-1:0] cls,
                                                 input t_cfg cfg);
        logic [COST_W-1:0] c;
        case (cls)
            CLS_OCC:  c = cfg.occupied_value;
            CLS_SEEN: c = cfg.background_value;
            default:  c = cfg.free_value;
        endcase
        return c;
    endfunction

    phbog_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    phbog_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_abs_n[DIV_W-1:0]),
        .i_divisor  (w_cfg.resolution),
        .o_res      (w_div)
    );

    phbog_ram #(
        .WIDTH (CLS_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_ram_rdata)
    );

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start & ~busy;

    // The divider sees the magnitude of (origin - coordinate). The ceiling
    // is rebuilt from the quotient and remainder: a positive numerator
    // rounds up when the remainder is nonzero, and a negative numerator
    // lands inside the grid only when its quotient is zero (index zero).
    always_comb begin
        w_on_y        = (r_state == S_YSTART) || (r_state == S_YWAIT);
        w_cur_n       = w_on_y ? r_ny : r_nx;
        w_abs_n       = w_cur_n[DIFF_W-1] ? (~w_cur_n + 1'b1) : w_cur_n;
        w_pos         = ~w_cur_n[DIFF_W-1] && (w_cur_n != '0);
        w_q_ceil      = {1'b0, w_div.quotient} + DIFF_W'(w_div.rem_nz);
        w_idx         = w_pos ? w_q_ceil : '0;
        w_idx_base_ok = w_pos || (w_div.quotient == '0);
        w_x_ok        = w_idx_base_ok && (w_idx < DIFF_W'(GRID_X));
        w_y_ok        = w_idx_base_ok && (w_idx < DIFF_W'(GRID_Y));
        w_div_start   = (r_state == S_XSTART) || (r_state == S_YSTART);
    end

    // Cell reads use 8-bit indexes against grids that may be wider.
    always_comb begin
        w_cx_ext       = {{(32 - CELL_W){1'b0}}, i_cell_x};
        w_cy_ext       = {{(32 - CELL_W){1'b0}}, i_cell_y};
        w_cell_in_grid = (w_cx_ext < 32'(GRID_X)) && (w_cy_ext < 32'(GRID_Y));
    end

    // An in-band point always makes the cell occupied; any other point only
    // promotes an empty cell to seen. A read always leaves the cell empty.
    always_comb begin
        if (r_is_read) begin
            w_new_cls = CLS_EMPTY;
        end else if (r_inband) begin
            w_new_cls = CLS_OCC;
        end else if (w_ram_rdata == CLS_EMPTY) begin
            w_new_cls = CLS_SEEN;
        end else begin
            w_new_cls = w_ram_rdata;
        end
        w_ram_we    = (r_state == S_CLEAR) || (r_state == S_MODIFY);
        w_ram_addr  = (r_state == S_CLEAR) ? r_clr : r_addr;
        w_ram_wdata = (r_state == S_CLEAR) ? CLS_EMPTY : w_new_cls;
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_nx        = r_nx;
        n_ny        = r_ny;
        n_inband    = r_inband;
        n_is_read   = r_is_read;
        n_ix        = r_ix;
        n_addr      = r_addr;
        n_out_valid = 1'b0;
        n_out_class = r_out_class;
        n_out_cost  = r_out_cost;

        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    if (!i_command) begin
                        n_is_read = 1'b0;
                        n_nx = {w_cfg.origin_x[COORD_W-1], w_cfg.origin_x}
                             - {i_point_x[COORD_W-1], i_point_x};
                        n_ny = {w_cfg.origin_y[COORD_W-1], w_cfg.origin_y}
                             - {i_point_y[COORD_W-1], i_point_y};
                        n_inband = (i_point_z <= $signed(w_cfg.max_height))
                                && (i_point_z >= $signed(w_cfg.min_height));
                        // A zero cell size drops every point.
                        if (w_cfg.resolution != '0) begin
                            n_state = S_XSTART;
                        end
                    end else begin
                        n_is_read = 1'b1;
                        if (w_cell_in_grid) begin
                            n_addr  = {w_cx_ext[XW-1:0], w_cy_ext[YW-1:0]};
                            n_state = S_FETCH;
                        end else begin
                            n_out_valid = 1'b1;
                            n_out_class = CLS_EMPTY;
                            n_out_cost  = w_cfg.free_value;
                        end
                    end
                end
            end
            S_XSTART: n_state = S_XWAIT;
            S_XWAIT: begin
                if (w_div.done) begin
                    n_ix    = w_idx[XW-1:0];
                    n_state = w_x_ok ? S_YSTART : S_IDLE;
                end
            end
            S_YSTART: n_state = S_YWAIT;
            S_YWAIT: begin
                if (w_div.done) begin
                    n_addr  = {r_ix, w_idx[YW-1:0]};
                    n_state = w_y_ok ? S_FETCH : S_IDLE;
                end
            end
            S_FETCH: n_state = S_MODIFY;
            S_MODIFY: begin
                n_state = S_IDLE;
                if (r_is_read) begin
                    n_out_valid = 1'b1;
                    n_out_class = w_ram_rdata;
                    n_out_cost  = f_cost(w_ram_rdata, w_cfg);
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
        r_nx        <= n_nx;
        r_ny        <= n_ny;
        r_inband    <= n_inband;
        r_is_read   <= n_is_read;
        r_ix        <= n_ix;
        r_addr      <= n_addr;
        r_out_class <= n_out_class;
        r_out_cost  <= n_out_cost;
    end

    assign o_result_valid = r_out_valid;
    assign o_cell_class   = r_out_class;
    assign o_cost         = r_out_cost;

`ifndef ASSERT_OFF
    a_no_bad_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_cell_class != CLS_BAD))
        else $error("result carries an undefined cell class");

    a_ram_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> ((r_state == S_CLEAR) || (r_state == S_MODIFY)))
        else $error("cell memory written outside clear or update");

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> ((r_state == S_XWAIT) || (r_state == S_YWAIT)))
        else $error("divider finished while no index was awaited");

    a_insert_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_command && (w_cfg.resolution != '0)) |=> (r_state == S_XSTART))
        else $error("accepted insert did not start the x division");
`endif

endmodule

`default_nettype wire

// File: verif/tb_point_height_band_occupancy_grid.sv
`timescale 1ns / 100ps

module tb_point_height_band_occupancy_grid;
    import phbog_pkg::*;

    // Request opcodes as carried on i_command.
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    localparam int     GRID_CELLS   = GRID_X_DEF * GRID_Y_DEF;
    localparam longint COORD_MIN    = -(longint'(1) << (COORD_W - 1));
    localparam longint COORD_MAX    = (longint'(1) << (COORD_W - 1)) - 1;
    // The drain outlasts the busy time of an insert, so it covers any insert
    // still in flight after the last cell report has come back.
    localparam int     DRAIN_CYCLES = 64;
    // The limit leaves a wide margin over the slowest correct run, which
    // includes the clearing sweep after reset.
    localparam int     CYCLE_LIMIT  = 1_000_000;
    localparam int     RANDOM_ITEMS = 1250;
    localparam int     NUM_PHASES   = 6;
    localparam int     WINDOW_SPAN  = 4;
    // Room for the owed cell reports and for the directed table.
    localparam int     REPORT_SLOTS   = 16;
    localparam int     DIRECTED_SLOTS = 64;

    typedef struct {
        logic                      command;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] pz;
        logic [CELL_W-1:0]         cx;
        logic [CELL_W-1:0]         cy;
    } t_grid_req;

    typedef struct {
        logic [CLS_W-1:0]  cls;
        logic [COST_W-1:0] cost;
    } t_cell_report;

    // One row of the directed table: either a register write or a request,
    // with an optional hand-written expectation for reads.
    typedef struct {
        bit                is_cfg;
        logic [2:0]        reg_idx;
        logic [APB_DW-1:0] reg_val;
        t_grid_req         req;
        bit                typed;
        t_cell_report      want;
    } t_stim_row;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic                      i_command;
    logic signed [COORD_W-1:0] i_point_x;
    logic signed [COORD_W-1:0] i_point_y;
    logic signed [COORD_W-1:0] i_point_z;
    logic [CELL_W-1:0]         i_cell_x;
    logic [CELL_W-1:0]         i_cell_y;
    logic                      o_result_valid;
    logic [CLS_W-1:0]          o_cell_class;
    logic [COST_W-1:0]         o_cost;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [APB_AW-1:0]         paddr;
    logic [APB_DW-1:0]         pwdata;
    logic [APB_DW-1:0]         prdata;
    logic                      pready;

    // Shadow copy of the block: its registers and its cell classes.
    t_cfg              shadow_cfg;
    logic [CLS_W-1:0]  shadow_cells [GRID_CELLS];

    // Cell reports that the block still owes, oldest first, kept in a ring.
    t_cell_report      pending_reports [REPORT_SLOTS];
    int                report_wr = 0;
    int                report_rd = 0;
    t_stim_row         directed_rows [DIRECTED_SLOTS];
    int                directed_count = 0;
    t_cell_report      monitor_want;
    int                mismatch_count = 0;
    int                cycle_count = 0;

    point_height_band_occupancy_grid uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_point_z      (i_point_z),
        .i_cell_x       (i_cell_x),
        .i_cell_y       (i_cell_y),
        .o_result_valid (o_result_valid),
        .o_cell_class   (o_cell_class),
        .o_cost         (o_cost),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // 2 ns clock period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("point_height_band_occupancy_grid test failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // Number of cell reports still owed by the block.
    function automatic int reports_owed();
        return report_wr - report_rd;
    endfunction

    // Appends one owed cell report to the ring.
    function automatic void owe_report(input t_cell_report rep);
        pending_reports[report_wr % REPORT_SLOTS] = rep;
        report_wr++;
    endfunction

    // Appends one row to the directed table.
    function automatic void add_row(input t_stim_row row);
        directed_rows[directed_count] = row;
        directed_count++;
    endfunction

    // Exact ceiling of n / d for d > 0, truncating division as in C.
    function automatic longint ceil_index(input longint n, input longint d);
        if (n > 0) begin
            return (n + d - 1) / d;
        end
        return -((-n) / d);
    endfunction

    // Applies one accepted request to the shadow grid. Returns 1 when the
    // request produces a cell report, which is then placed in rep.
    function automatic bit predict_cell_access(input t_grid_req r, output t_cell_report rep);
        longint ix;
        longint iy;
        longint res;
        longint z;
        int     addr;
        rep.cls  = CLS_EMPTY;
        rep.cost = shadow_cfg.free_value;
        if (r.command == CMD_INSERT) begin
            res = longint'(shadow_cfg.resolution);
            // A zero resolution drops every point without dividing.
            if (res == 0) begin
                return 1'b0;
            end
            ix = ceil_index(longint'($signed(shadow_cfg.origin_x)) - longint'(r.px), res);
            iy = ceil_index(longint'($signed(shadow_cfg.origin_y)) - longint'(r.py), res);
            if (ix < 0 || ix >= GRID_X_DEF || iy < 0 || iy >= GRID_Y_DEF) begin
                return 1'b0;
            end
            addr = int'(ix) * GRID_Y_DEF + int'(iy);
            z = longint'(r.pz);
            // With an inverted band this test never holds, so points can
            // only mark cells as seen.
            if (z <= longint'($signed(shadow_cfg.max_height)) &&
                z >= longint'($signed(shadow_cfg.min_height))) begin
                shadow_cells[addr] = CLS_OCC;
            end else if (shadow_cells[addr] == CLS_EMPTY) begin
                shadow_cells[addr] = CLS_SEEN;
            end
            return 1'b0;
        end
        // A read reports the cell and then clears it.
        addr = int'(r.cx) * GRID_Y_DEF + int'(r.cy);
        rep.cls = shadow_cells[addr];
        shadow_cells[addr] = CLS_EMPTY;
        if (rep.cls == CLS_OCC) begin
            rep.cost = shadow_cfg.occupied_value;
        end else if (rep.cls == CLS_SEEN) begin
            rep.cost = shadow_cfg.background_value;
        end
        return 1'b1;
    endfunction

    // Presents one request after a gap of idle cycles and holds it until the
    // block takes it. With a gap of zero, start simply stays high.
    task automatic send_request(input t_grid_req r, input int gap, input bit typed,
                                input t_cell_report typed_rep);
        t_cell_report rep;
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start     <= 1'b1;
        i_command <= r.command;
        i_point_x <= r.px;
        i_point_y <= r.py;
        i_point_z <= r.pz;
        i_cell_x  <= r.cx;
        i_cell_y  <= r.cy;
        do @(posedge i_clk); while (busy !== 1'b0);
        // Accepted at this edge. Reads owe a report; a hand-written
        // expectation, where the table gives one, stands in for the shadow's.
        if (predict_cell_access(r, rep)) begin
            owe_report(typed ? typed_rep : rep);
        end
    endtask

    // Drops start and waits until the block has nothing left to do, so that
    // a register can be changed safely.
    task automatic wait_idle();
        @(negedge i_clk);
        start <= 1'b0;
        while (reports_owed() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic write_reg(input logic [2:0] idx, input logic [APB_DW-1:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        case (idx)
            REG_ORIGIN_X:   shadow_cfg.origin_x         = val[COORD_W-1:0];
            REG_ORIGIN_Y:   shadow_cfg.origin_y         = val[COORD_W-1:0];
            REG_RESOLUTION: shadow_cfg.resolution       = val[RES_W-1:0];
            REG_MAX_HEIGHT: shadow_cfg.max_height       = val[COORD_W-1:0];
            REG_MIN_HEIGHT: shadow_cfg.min_height       = val[COORD_W-1:0];
            REG_FREE_VAL:   shadow_cfg.free_value       = val[COST_W-1:0];
            REG_OCC_VAL:    shadow_cfg.occupied_value   = val[COST_W-1:0];
            REG_BG_VAL:     shadow_cfg.background_value = val[COST_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Directed table builders.
    function automatic void add_cfg(input logic [2:0] idx, input longint val);
        t_stim_row row;
        row.is_cfg      = 1'b1;
        row.reg_idx     = idx;
        row.reg_val     = val[APB_DW-1:0];
        row.req.command = CMD_INSERT;
        row.req.px      = '0;
        row.req.py      = '0;
        row.req.pz      = '0;
        row.req.cx      = '0;
        row.req.cy      = '0;
        row.typed       = 1'b0;
        row.want.cls    = CLS_EMPTY;
        row.want.cost   = '0;
        add_row(row);
    endfunction

    function automatic void add_insert(input longint x, input longint y, input longint z);
        t_stim_row row;
        row.is_cfg      = 1'b0;
        row.reg_idx     = REG_ORIGIN_X;
        row.reg_val     = '0;
        row.req.command = CMD_INSERT;
        row.req.px      = x[COORD_W-1:0];
        row.req.py      = y[COORD_W-1:0];
        row.req.pz      = z[COORD_W-1:0];
        row.req.cx      = '0;
        row.req.cy      = '0;
        row.typed       = 1'b0;
        row.want.cls    = CLS_EMPTY;
        row.want.cost   = '0;
        add_row(row);
    endfunction

    function automatic void add_read(input int cx, input int cy, input bit typed,
                                     input logic [CLS_W-1:0] cls,
                                     input logic [COST_W-1:0] cost);
        t_stim_row row;
        row.is_cfg      = 1'b0;
        row.reg_idx     = REG_ORIGIN_X;
        row.reg_val     = '0;
        row.req.command = CMD_READ;
        row.req.px      = '0;
        row.req.py      = '0;
        row.req.pz      = '0;
        row.req.cx      = cx[CELL_W-1:0];
        row.req.cy      = cy[CELL_W-1:0];
        row.typed       = typed;
        row.want.cls    = cls;
        row.want.cost   = cost;
        add_row(row);
    endfunction

    // Picks the low corner of a small window of cells that the random part
    // keeps hitting, so that reads find cells that inserts have touched.
    // The window stays where its points still fit the coordinate range.
    function automatic int window_base(input longint origin, input longint res);
        longint lim;
        lim = (origin - COORD_MIN) / res - WINDOW_SPAN;
        if (lim > GRID_X_DEF - WINDOW_SPAN) begin
            lim = GRID_X_DEF - WINDOW_SPAN;
        end
        if (lim < 0) begin
            lim = 0;
        end
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return int'(lim);
            default: return int'($urandom_range(0, int'(lim)));
        endcase
    endfunction

    // Builds a coordinate that lands in a chosen cell of the window, or now
    // and then just past either edge of the grid.
    function automatic logic signed [COORD_W-1:0] coord_for_index(input longint origin,
                                                                  input longint res,
                                                                  input int base);
        longint idx;
        longint p;
        if ($urandom_range(0, 15) == 0) begin
            idx = ($urandom_range(0, 1) == 1) ? longint'(-1) : longint'(GRID_X_DEF);
        end else begin
            idx = longint'(base) + longint'($urandom_range(0, WINDOW_SPAN - 1));
        end
        p = origin - idx * res;
        if (idx >= 0 && res > 1) begin
            p = p + longint'($urandom_range(0, int'(res - 1)));
        end
        if (p < COORD_MIN || p > COORD_MAX) begin
            p = origin;
        end
        return p[COORD_W-1:0];
    endfunction

    // Heights cluster around the band and around its lower and upper edges.
    function automatic logic signed [COORD_W-1:0] pick_height();
        longint zmin;
        longint zmax;
        longint lo;
        longint hi;
        longint z;
        zmin = longint'($signed(shadow_cfg.min_height));
        zmax = longint'($signed(shadow_cfg.max_height));
        lo = (zmin < zmax) ? zmin : zmax;
        hi = (zmin < zmax) ? zmax : zmin;
        case ($urandom_range(0, 9))
            5:       z = zmin;
            6:       z = zmax;
            7:       z = zmin - 1;
            8:       z = zmax + 1;
            9:       z = longint'($urandom_range(0, 2097151)) + COORD_MIN;
            default: z = lo - 2 + longint'($urandom_range(0, int'(hi - lo + 4)));
        endcase
        return z[COORD_W-1:0];
    endfunction

    // Result checker: every strobe must match the oldest owed cell report.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_result_valid === 1'b1) begin
            if (reports_owed() == 0) begin
                report_mismatch($sformatf("unexpected report class %0d cost 0x%04h",
                                          o_cell_class, o_cost));
            end else begin
                monitor_want = pending_reports[report_rd % REPORT_SLOTS];
                report_rd++;
                if (o_cell_class !== monitor_want.cls) begin
                    report_mismatch($sformatf("cell class %0d, expected %0d",
                                              o_cell_class, monitor_want.cls));
                end
                if (o_cost !== monitor_want.cost) begin
                    report_mismatch($sformatf("cost 0x%04h, expected 0x%04h",
                                              o_cost, monitor_want.cost));
                end
            end
        end
    end

    initial begin
        int           k;
        int           phase;
        int           n;
        int           gap;
        int           pick;
        int           base_x;
        int           base_y;
        bit           burst;
        longint       ox;
        longint       oy;
        longint       res;
        longint       zmin;
        longint       zmax;
        longint       free_v;
        longint       occ_v;
        longint       bg_v;
        t_grid_req    req;
        t_cell_report no_rep;

        // Every input starts at a known value.
        i_rst_n   = 1'b0;
        start     = 1'b0;
        i_command = CMD_INSERT;
        i_point_x = '0;
        i_point_y = '0;
        i_point_z = '0;
        i_cell_x  = '0;
        i_cell_y  = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        no_rep.cls  = CLS_EMPTY;
        no_rep.cost = '0;
        burst  = 1'b0;
        base_x = 0;
        base_y = 0;
        ox     = 0;
        oy     = 0;
        res    = longint'(RST_RESOLUTION);

        shadow_cfg.origin_x         = RST_ORIGIN_X;
        shadow_cfg.origin_y         = RST_ORIGIN_Y;
        shadow_cfg.resolution       = RST_RESOLUTION;
        shadow_cfg.max_height       = RST_MAX_HEIGHT;
        shadow_cfg.min_height       = RST_MIN_HEIGHT;
        shadow_cfg.free_value       = RST_FREE_VAL;
        shadow_cfg.occupied_value   = RST_OCC_VAL;
        shadow_cfg.background_value = RST_BG_VAL;
        foreach (shadow_cells[i]) begin
            shadow_cells[i] = CLS_EMPTY;
        end

        // Directed table. With the reset registers a cell of index i on an
        // axis is reached by a coordinate of -100*i.
        // An untouched cell right after reset reads as empty at the free cost.
        add_read(0, 0, 1'b1, CLS_EMPTY, RST_FREE_VAL);
        // An in-band point occupies its cell; the read clears it again.
        add_insert(0, 0, 0);
        add_read(0, 0, 1'b1, CLS_OCC, RST_OCC_VAL);
        add_read(0, 0, 1'b1, CLS_EMPTY, RST_FREE_VAL);
        // Distinct costs so that each class is told apart by its cost.
        add_cfg(REG_FREE_VAL, 16'h0007);
        add_cfg(REG_OCC_VAL, 16'hFFFF);
        add_cfg(REG_BG_VAL, 16'h1234);
        // Points above and below the band only mark the cell as seen.
        add_insert(-100, -100, 2001);
        add_insert(-100, -100, -1001);
        add_read(1, 1, 1'b1, CLS_SEEN, 16'h1234);
        // The top edge of the band counts; a later out-of-band point on an
        // occupied cell leaves it occupied.
        add_insert(-100, -200, 2000);
        add_insert(-100, -200, COORD_MAX);
        add_read(1, 2, 1'b1, CLS_OCC, 16'hFFFF);
        // The bottom edge of the band counts too, with rounding up on the y axis.
        add_insert(-200, -101, -1000);
        // Far corner of the grid, with the lowest possible height.
        add_insert(-25500, -25500, COORD_MIN);
        // Points just past either edge and at the coordinate extremes drop.
        add_insert(-25501, 0, 0);
        add_insert(100, 0, 0);
        add_insert(COORD_MIN, COORD_MAX, 0);
        add_read(2, 2, 1'b0, CLS_EMPTY, '0);
        add_read(255, 255, 1'b1, CLS_SEEN, 16'h1234);
        add_read(255, 0, 1'b0, CLS_EMPTY, '0);
        // A small positive offset still rounds up to index zero.
        add_insert(50, 99, 0);
        add_read(0, 0, 1'b0, CLS_EMPTY, '0);
        // Inverted band: nothing is in band, so a point only marks seen.
        add_cfg(REG_MIN_HEIGHT, 5);
        add_cfg(REG_MAX_HEIGHT, -5);
        add_insert(0, 0, 0);
        add_read(0, 0, 1'b1, CLS_SEEN, 16'h1234);
        // Zero resolution: every point is dropped.
        add_cfg(REG_RESOLUTION, 0);
        add_insert(0, 0, -5);
        add_read(0, 0, 1'b1, CLS_EMPTY, 16'h0007);

        // Reset is held low from time zero and released on a falling edge.
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The first request simply waits out the clearing sweep on busy.
        for (k = 0; k < directed_count; k++) begin
            if (directed_rows[k].is_cfg) begin
                wait_idle();
                write_reg(directed_rows[k].reg_idx, directed_rows[k].reg_val);
            end else begin
                send_request(directed_rows[k].req, $urandom_range(0, 14),
                             directed_rows[k].typed, directed_rows[k].want);
            end
        end

        // Random part: each phase sets all registers, then runs a mix of
        // requests aimed at a small window of cells with some noise.
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            zmin   = -longint'($urandom_range(0, 3000));
            zmax   = longint'($urandom_range(0, 3000));
            free_v = longint'($urandom_range(0, 65535));
            occ_v  = longint'($urandom_range(0, 65535));
            bg_v   = longint'($urandom_range(0, 65535));
            ox     = longint'($urandom_range(0, 30000)) - 5000;
            oy     = longint'($urandom_range(0, 30000)) - 5000;
            res    = longint'($urandom_range(50, 300));
            case (phase)
                1: begin
                    // Finest resolution, origins at opposite extremes, a band
                    // that takes every height.
                    ox = COORD_MAX;
                    oy = COORD_MIN;
                    res = 1;
                    zmin = COORD_MIN;
                    zmax = COORD_MAX;
                    free_v = 0;
                    occ_v = 16'hFFFF;
                    bg_v = 0;
                end
                2: begin
                    // Coarsest resolution and a band of a single height.
                    ox = COORD_MIN;
                    oy = COORD_MAX;
                    res = 65535;
                    zmin = longint'($urandom_range(0, 4000)) - 2000;
                    zmax = zmin;
                    free_v = 16'hFFFF;
                    occ_v = 0;
                    bg_v = 16'hFFFF;
                end
                3: begin
                    zmin = longint'($urandom_range(0, 2000));
                    zmax = zmin - longint'($urandom_range(1, 2000));
                end
                4: begin
                    ox = longint'($urandom_range(0, 2097151)) + COORD_MIN;
                    oy = longint'($urandom_range(0, 2097151)) + COORD_MIN;
                    res = longint'($urandom_range(1, 65535));
                end
                5: begin
                    res = longint'($urandom_range(1, 16));
                    ox = longint'($urandom_range(0, 4096));
                    oy = longint'($urandom_range(0, 4096));
                end
                default: ;
            endcase
            wait_idle();
            write_reg(REG_ORIGIN_X, 32'(ox));
            write_reg(REG_ORIGIN_Y, 32'(oy));
            write_reg(REG_RESOLUTION, 32'(res));
            write_reg(REG_MAX_HEIGHT, 32'(zmax));
            write_reg(REG_MIN_HEIGHT, 32'(zmin));
            write_reg(REG_FREE_VAL, 32'(free_v));
            write_reg(REG_OCC_VAL, 32'(occ_v));
            write_reg(REG_BG_VAL, 32'(bg_v));

            for (n = 0; n < RANDOM_ITEMS / NUM_PHASES; n++) begin
                if (n % 40 == 0) begin
                    base_x = window_base(ox, res);
                    base_y = window_base(oy, res);
                end
                // Now and then a stretch of back-to-back requests.
                if (n % 32 == 0) begin
                    burst = ($urandom_range(0, 3) == 0);
                end
                // Start from fully random fields, then shape by kind.
                req.command = CMD_INSERT;
                req.px = COORD_W'($urandom());
                req.py = COORD_W'($urandom());
                req.pz = COORD_W'($urandom());
                req.cx = CELL_W'($urandom());
                req.cy = CELL_W'($urandom());
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    req.px = coord_for_index(ox, res, base_x);
                    req.py = coord_for_index(oy, res, base_y);
                    req.pz = pick_height();
                end else if (pick >= 55) begin
                    req.command = CMD_READ;
                    if (pick < 92) begin
                        req.cx = CELL_W'(base_x + int'($urandom_range(0, WINDOW_SPAN - 1)));
                        req.cy = CELL_W'(base_y + int'($urandom_range(0, WINDOW_SPAN - 1)));
                    end
                end
                gap = burst ? 0 : $urandom_range(0, 14);
                send_request(req, gap, 1'b0, no_rep);
            end
        end

        // Drain: every owed report must arrive, then stray strobes get a
        // chance to show up before the verdict.
        @(negedge i_clk);
        start <= 1'b0;
        while (reports_owed() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (reports_owed() != 0) begin
            report_mismatch($sformatf("%0d cell reports never arrived",
                                      reports_owed()));
        end
        if (mismatch_count == 0) begin
            $display("point_height_band_occupancy_grid test passed");
        end else begin
            $display("point_height_band_occupancy_grid test failed");
        end
        $finish;
    end

endmodule
